>>> design/lfst_pkg.sv
package lfst_pkg;

    // Field widths fixed by the channel format
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Occupancy bitmap is kept as words of this many slots
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // Growth constants
    localparam int unsigned FIRST_SIZE = 1;
    localparam int unsigned GROW_STEP  = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TAS = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IN_USE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FIND,
        ST_SCAN,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic find;
        logic scan;
        logic load;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_search;
    } dp_stat_t;

endpackage

>>> design/lfst_req_if.sv
interface lfst_req_if #(
    parameter int VALUE_WIDTH = 32
);
    import lfst_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [IDX_W-1:0]       slot_index;
    logic [VALUE_WIDTH-1:0] handle_value;

    modport source (output valid, func, slot_index, handle_value, input ready);
    modport sink   (input valid, func, slot_index, handle_value, output ready);

endinterface

>>> design/lfst_rsp_if.sv
interface lfst_rsp_if;
    import lfst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    placed_index;
    logic [CNT_W-1:0]    free_count_out;
    logic [CNT_W-1:0]    lowest_free_out;
    logic [CNT_W-1:0]    size_in_use_out;

    modport source (
        output valid, status, placed_index, free_count_out, lowest_free_out,
               size_in_use_out,
        input  ready
    );
    modport sink (
        input  valid, status, placed_index, free_count_out, lowest_free_out,
               size_in_use_out,
        output ready
    );

endinterface

>>> design/lfst_ram.sv
module lfst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/lfst_ctrl.sv
module lfst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output lfst_pkg::ctl_cmd_t cmd,
    input  lfst_pkg::dp_stat_t stat
);
    import lfst_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       can_load;
    logic       accept;

    assign can_load = !rsp_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = stat.need_search ? ST_FIND : ST_DONE;
            end
            ST_FIND:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (can_load)
                begin
                    state_next = req_valid ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            ST_FIND:
            begin
                cmd.find = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DONE:
            begin
                req_ready = can_load;
                cmd.load  = can_load;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        accept     = req_ready && req_valid;
        cmd.accept = accept;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

>>> design/lfst_dp.sv
module lfst_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lfst_pkg::ctl_cmd_t              cmd,
    output lfst_pkg::dp_stat_t              stat,
    input  logic [lfst_pkg::FUNC_W-1:0]     func,
    input  logic [lfst_pkg::IDX_W-1:0]      slot_index,
    input  logic [VALUE_WIDTH-1:0]          handle_value,
    input  logic                            cfg_we,
    input  logic [lfst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfst_pkg::CNT_W-1:0]      cfg_data,
    output logic [lfst_pkg::STATUS_W-1:0]   status,
    output logic [lfst_pkg::IDX_W-1:0]      placed_index,
    output logic [lfst_pkg::CNT_W-1:0]      free_count_out,
    output logic [lfst_pkg::CNT_W-1:0]      lowest_free_out,
    output logic [lfst_pkg::CNT_W-1:0]      size_in_use_out
);
    import lfst_pkg::*;

    localparam int SZW    = $clog2(TABLE_DEPTH + 1);
    localparam int LW     = $clog2(TABLE_DEPTH + 2);
    localparam int AW     = ((SZW > CNT_W) ? SZW : CNT_W) + 2;
    localparam int NWORDS = (TABLE_DEPTH + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LIM_MAX = TABLE_DEPTH + 1;

    // table state
    logic [SZW-1:0]    size_reg;
    logic [SZW-1:0]    free_reg;
    logic [SZW-1:0]    lowest_reg;
    logic [LW-1:0]     lim_reg;
    logic [NWORDS-1:0] valid_reg;
    logic [NWORDS-1:0] full_reg;
    logic              rd_vld_reg;

    // item in flight
    logic [FUNC_W-1:0]   op_func_reg;
    logic [IDX_W-1:0]    op_idx_reg;
    logic                op_nz_reg;
    logic [WAW-1:0]      op_word_reg;
    logic [BIT_W-1:0]    op_bit_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [IDX_W-1:0]    placed_reg;
    logic [WAW-1:0]      found_w_reg;
    logic                found_any_reg;

    // result register
    logic [STATUS_W-1:0] out_status_reg;
    logic [IDX_W-1:0]    out_placed_reg;
    logic [CNT_W-1:0]    out_free_reg;
    logic [CNT_W-1:0]    out_lowest_reg;
    logic [CNT_W-1:0]    out_size_reg;

    // bitmap memory
    logic                 ram_we;
    logic                 ram_re;
    logic [WAW-1:0]       ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word_now;
    logic [WORD_BITS-1:0] new_word;

    logic [WAW-1:0]   acc_word;
    logic [BIT_W-1:0] acc_bit;

    // lookup step
    logic [AW-1:0]       size_a;
    logic [AW-1:0]       free_a;
    logic [AW-1:0]       idx_a;
    logic [AW-1:0]       lim_a;
    logic [AW-1:0]       low_a;
    logic [AW-1:0]       soft_add;
    logic [AW-1:0]       soft_set;
    logic [AW-1:0]       hard_set;
    logic [AW-1:0]       n_set;
    logic                add_grow_ok;
    logic                set_grow_ok;
    logic                need_grow_set;
    logic                occupied;
    logic [STATUS_W-1:0] status_n;
    logic [IDX_W-1:0]    placed_n;
    logic [AW-1:0]       size_n;
    logic [AW-1:0]       free_n;
    logic [AW-1:0]       low_n;
    logic                do_write;
    logic                new_bit;
    logic                need_search;

    // search steps
    logic             found_any;
    logic [WAW-1:0]   found_w;
    logic [BIT_W-1:0] zero_b;
    logic [AW-1:0]    cand;
    logic [AW-1:0]    scan_low;

    assign word_now = rd_vld_reg ? ram_rdata : '0;

    always_comb
    begin
        if (func == FUNC_ADD)
        begin
            acc_word = WAW'(lowest_reg >> BIT_W);
            acc_bit  = BIT_W'(lowest_reg);
        end
        else
        begin
            acc_word = WAW'(slot_index >> BIT_W);
            acc_bit  = BIT_W'(slot_index);
        end
    end

    always_comb
    begin
        size_a   = AW'(size_reg);
        free_a   = AW'(free_reg);
        idx_a    = AW'(op_idx_reg);
        lim_a    = AW'(lim_reg);
        low_a    = AW'(lowest_reg);

        soft_add    = (size_reg == '0) ? AW'(FIRST_SIZE) : size_a * AW'(GROW_STEP);
        add_grow_ok = (soft_add < lim_a) && (soft_add > size_a);

        // next multiple of the growth step above the index, else index plus one
        soft_set    = (idx_a / AW'(GROW_STEP) + AW'(1)) * AW'(GROW_STEP);
        hard_set    = idx_a + AW'(1);
        n_set       = (soft_set > lim_a) ? hard_set : soft_set;
        set_grow_ok = !((soft_set > lim_a) && (hard_set > lim_a)) &&
                      (n_set < lim_a) && (n_set > size_a);
        need_grow_set = (idx_a >= size_a);
        occupied      = word_now[op_bit_reg] && !need_grow_set;

        status_n    = STATUS_OK;
        placed_n    = op_idx_reg;
        size_n      = size_a;
        free_n      = free_a;
        low_n       = low_a;
        do_write    = 1'b0;
        new_bit     = op_nz_reg;
        need_search = 1'b0;

        case (op_func_reg)
            FUNC_ADD:
            begin
                placed_n = '0;
                if (!op_nz_reg)
                begin
                    status_n = STATUS_ZERO;
                end
                else if ((free_reg == '0) && !add_grow_ok)
                begin
                    status_n = STATUS_NO_ROOM;
                end
                else
                begin
                    // growth leaves the lowest free slot at the old size
                    if (free_reg == '0)
                    begin
                        size_n = soft_add;
                        free_n = soft_add - size_a;
                    end
                    free_n      = free_n - AW'(1);
                    placed_n    = IDX_W'(lowest_reg);
                    do_write    = 1'b1;
                    new_bit     = 1'b1;
                    need_search = 1'b1;
                end
            end
            FUNC_SET, FUNC_TAS:
            begin
                if ((op_func_reg == FUNC_TAS) && !op_nz_reg)
                begin
                    status_n = STATUS_ZERO;
                end
                else if ((op_func_reg == FUNC_TAS) && occupied)
                begin
                    status_n = STATUS_IN_USE;
                end
                else if (need_grow_set && !set_grow_ok)
                begin
                    status_n = STATUS_NO_ROOM;
                end
                else if (idx_a >= AW'(TABLE_DEPTH))
                begin
                    status_n = STATUS_NO_ROOM;
                end
                else
                begin
                    if (need_grow_set)
                    begin
                        size_n = n_set;
                        free_n = free_a + n_set - size_a;
                    end
                    do_write = 1'b1;
                    if (!occupied && op_nz_reg)
                    begin
                        free_n      = free_n - AW'(1);
                        need_search = (idx_a == low_a);
                    end
                    else if (occupied && !op_nz_reg)
                    begin
                        free_n = free_n + AW'(1);
                        if (idx_a < low_a)
                        begin
                            low_n = idx_a;
                        end
                    end
                end
            end
            default:
            begin
                status_n = STATUS_OK;
            end
        endcase

        new_word             = word_now;
        new_word[op_bit_reg] = new_bit;
    end

    assign stat.need_search = need_search;

    // lowest word with a free slot
    always_comb
    begin
        found_any = 1'b0;
        found_w   = '0;
        for (int i = NWORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                found_any = 1'b1;
                found_w   = WAW'(i);
            end
        end
    end

    // lowest clear bit of the fetched word
    always_comb
    begin
        zero_b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word_now[i])
            begin
                zero_b = BIT_W'(i);
            end
        end
        cand     = AW'({found_w_reg, zero_b});
        scan_low = (found_any_reg && (cand < AW'(size_reg))) ? cand : AW'(size_reg);
    end

    assign ram_we    = cmd.lookup && do_write;
    assign ram_re    = cmd.accept || cmd.find;
    assign ram_raddr = cmd.accept ? acc_word : found_w;

    lfst_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_word_reg),
        .wdata (new_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= '0;
            free_reg   <= '0;
            lowest_reg <= '0;
            lim_reg    <= LW'(LIM_MAX);
            valid_reg  <= '0;
            full_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ram_re)
            begin
                rd_vld_reg <= valid_reg[ram_raddr];
            end
            if (cmd.lookup)
            begin
                size_reg   <= SZW'(size_n);
                free_reg   <= SZW'(free_n);
                lowest_reg <= SZW'(low_n);
                if (do_write)
                begin
                    valid_reg[op_word_reg] <= 1'b1;
                    full_reg[op_word_reg]  <= &new_word;
                end
            end
            if (cmd.scan)
            begin
                lowest_reg <= SZW'(scan_low);
            end
            if (cfg_we && (cfg_index == CFG_INITIAL_SIZE))
            begin
                // re-initialize: drop every word, size and free count from the write
                valid_reg  <= '0;
                full_reg   <= '0;
                lowest_reg <= '0;
                if (AW'(cfg_data) > AW'(TABLE_DEPTH))
                begin
                    size_reg <= SZW'(TABLE_DEPTH);
                    free_reg <= SZW'(TABLE_DEPTH);
                end
                else
                begin
                    size_reg <= SZW'(cfg_data);
                    free_reg <= SZW'(cfg_data);
                end
            end
            if (cfg_we && (cfg_index == CFG_SIZE_LIMIT))
            begin
                if (AW'(cfg_data) > AW'(LIM_MAX))
                begin
                    lim_reg <= LW'(LIM_MAX);
                end
                else
                begin
                    lim_reg <= LW'(cfg_data);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_func_reg <= func;
            op_idx_reg  <= slot_index;
            op_nz_reg   <= |handle_value;
            op_word_reg <= acc_word;
            op_bit_reg  <= acc_bit;
        end
        if (cmd.lookup)
        begin
            st_reg     <= status_n;
            placed_reg <= placed_n;
        end
        if (cmd.find)
        begin
            found_w_reg   <= found_w;
            found_any_reg <= found_any;
        end
        if (cmd.load)
        begin
            out_status_reg <= st_reg;
            out_placed_reg <= placed_reg;
            out_free_reg   <= CNT_W'(free_reg);
            out_lowest_reg <= CNT_W'(lowest_reg);
            out_size_reg   <= CNT_W'(size_reg);
        end
    end

    assign status          = out_status_reg;
    assign placed_index    = out_placed_reg;
    assign free_count_out  = out_free_reg;
    assign lowest_free_out = out_lowest_reg;
    assign size_in_use_out = out_size_reg;

endmodule

>>> design/lowest_free_slot_table_top.sv
// Lowest-free-slot handle table.
// req channel carries one command word: func (add, set, test-and-set),
// slot_index and handle_value. rsp channel returns one word per command:
// status, placed slot, and the free count, lowest free slot and size in use
// after the command. cfg_we/cfg_index/cfg_data write initial_size (index 0,
// re-initializes the table) and size_limit (index 1); write only while idle.
// Occupancy is a bitmap of 32-slot words in a RAM, with a full flag per word.
// From accept to rsp.valid, when the lowest free slot does not move: bitmap
// read, then read-modify-write, then output load. When it must be searched
// again, a priority pick over the full flags, then a second bitmap read and
// a bit search come before the load. A new command is accepted only once
// the previous one is loaded into the output register or the block is idle.
// Reset clears every word's valid bit at once (no clearing pass), sets size
// in use and free count to zero and size_limit to TABLE_DEPTH+1.
// A stalled rsp holds its word in the output register; the next command is
// accepted and processed, then waits until the output register is taken.
module lowest_free_slot_table_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lfst_req_if.sink                       req,
    lfst_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [lfst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfst_pkg::CNT_W-1:0]     cfg_data
);
    import lfst_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    lfst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lfst_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .func            (req.func),
        .slot_index      (req.slot_index),
        .handle_value    (req.handle_value),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .status          (rsp.status),
        .placed_index    (rsp.placed_index),
        .free_count_out  (rsp.free_count_out),
        .lowest_free_out (rsp.lowest_free_out),
        .size_in_use_out (rsp.size_in_use_out)
    );

    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> cmd.lookup)
        else $error("accepted word did not enter lookup");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.lookup, cmd.find, cmd.scan, cmd.load}))
        else $error("more than one datapath step at once");

    a_find_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find |=> cmd.scan)
        else $error("search pick not followed by bit scan");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.free_count_out <= rsp.size_in_use_out) &&
                       (rsp.lowest_free_out <= rsp.size_in_use_out)))
        else $error("free count or lowest free slot beyond size in use");

endmodule
